@@ rtl/core/cpsa_pkg.sv @@
// cpsa_pkg: word types, sizes and active-width constants for the cube pair
// support accumulator. No dependencies; imported by cube_pair_support_accumulator.
`timescale 1ns / 1ps

package cpsa_pkg;

   // Configured problem size
   localparam int CUBE_VAR_COUNT = 16;  // 1..32
   localparam int NUM_OUTPUTS    = 16;  // 1..64

   // Field capacity: 16 variables (two bits each) and 16 outputs per word
   localparam int FIELD_VARS = 16;
   localparam int FIELD_OUTS = 16;
   localparam int VAR_IDX_W  = 4;
   localparam int ROW_IDX_W  = 4;

   // Only variables and outputs below both limits take part
   localparam int ACT_VARS = (CUBE_VAR_COUNT < FIELD_VARS) ? CUBE_VAR_COUNT : FIELD_VARS;
   localparam int ACT_OUTS = (NUM_OUTPUTS < FIELD_OUTS) ? NUM_OUTPUTS : FIELD_OUTS;

   // Request kinds
   localparam logic REQ_PAIR = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef logic [FIELD_VARS-1:0] row_type;

   typedef struct packed {
      logic                      req_type;
      logic [2*FIELD_VARS-1:0]   on_cube_inputs;
      logic [FIELD_OUTS-1:0]     on_cube_outputs;
      logic [2*FIELD_VARS-1:0]   off_cube_inputs;
      logic [FIELD_OUTS-1:0]     off_cube_outputs;
      logic [ROW_IDX_W-1:0]      row_select;
   } req_word_type;

   typedef struct packed {
      row_type                   support_row;
      logic [VAR_IDX_W-1:0]      conflict_var;
      logic                      var_found;
      logic [FIELD_OUTS-1:0]     shared_outputs;
   } rsp_word_type;

endpackage

@@ rtl/core/cube_pair_support_accumulator.sv @@
// Cube pair support accumulator: input register, conflict logic, support
// matrix and result register in one module. Depends on cpsa_pkg.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready/req_data): one word per cube pair or per
//   row read. A pair word ORs its single conflicting variable into the support
//   row of every shared output when the output parts intersect and exactly one
//   variable has codes that XOR to 11. A read word returns one support row.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one word per request,
//   in request order.
//   An accepted word goes to the input register and its result to the result
//   register, which drives rsp_data. Throughput: one word per cycle unless the
//   receiver stalls; the matrix update and row read happen in the single logic
//   stage between the two registers, so a read sees every earlier pair.
//   Reset (synchronous, active high) clears the support matrix and both
//   valid flags in the same cycle; the block is ready right after.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; req_ready drops only when both are full.
module cube_pair_support_accumulator
   import cpsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_data,

   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data
);

   // Pipeline registers
   logic          s1_valid_ff, s1_valid_in;
   req_word_type  s1_word_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // Support matrix, row o belongs to output o
   row_type       matrix_ff [FIELD_OUTS];
   row_type       matrix_in [FIELD_OUTS];

   logic                   out_free;
   logic                   s1_advance;
   logic [2*FIELD_VARS-1:0] code_xor;
   row_type                conf;
   logic [FIELD_OUTS-1:0]  shared;
   logic                   single_conf;
   logic                   pair_hit;
   logic [VAR_IDX_W-1:0]   conf_idx;
   row_type                read_row;

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_word_ff;

   // Conflict detection over the active variables
   always_comb begin
      code_xor = s1_word_ff.on_cube_inputs ^ s1_word_ff.off_cube_inputs;
      conf     = '0;
      conf_idx = '0;
      for (int v = 0; v < ACT_VARS; v++) begin
         conf[v] = code_xor[2*v] & code_xor[2*v+1];
      end
      // conf is one-hot when it is used, so an OR of indexes encodes it
      for (int v = 0; v < FIELD_VARS; v++) begin
         if (conf[v]) begin
            conf_idx = conf_idx | VAR_IDX_W'(v);
         end
      end
      shared = '0;
      for (int o = 0; o < ACT_OUTS; o++) begin
         shared[o] = s1_word_ff.on_cube_outputs[o] & s1_word_ff.off_cube_outputs[o];
      end
      single_conf = (conf != '0) && ((conf & (conf - row_type'(1))) == '0);
      pair_hit    = (s1_word_ff.req_type == REQ_PAIR) && (shared != '0) && single_conf;
   end

   // Row read
   always_comb begin
      read_row = '0;
      if ({1'b0, s1_word_ff.row_select} < (ROW_IDX_W+1)'(ACT_OUTS)) begin
         read_row = matrix_ff[s1_word_ff.row_select];
      end
   end

   // Matrix update: set the conflicting variable in each shared output's row
   always_comb begin
      for (int o = 0; o < FIELD_OUTS; o++) begin
         matrix_in[o] = matrix_ff[o];
         if (s1_advance && pair_hit && shared[o]) begin
            matrix_in[o] = matrix_ff[o] | conf;
         end
      end
   end

   // Result word
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (s1_advance) begin
         rsp_word_in = '0;
         if (s1_word_ff.req_type == REQ_READ) begin
            rsp_word_in.support_row = read_row;
         end else begin
            rsp_word_in.shared_outputs = shared;
            rsp_word_in.var_found      = pair_hit;
            rsp_word_in.conflict_var   = pair_hit ? conf_idx : '0;
         end
      end
   end

   // Valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int o = 0; o < FIELD_OUTS; o++) begin
            matrix_ff[o] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_data;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

@@ sim/tb_cube_pair_support_accumulator.sv @@
// Self-checking testbench for cube_pair_support_accumulator: directed and random
// cube pairs and row reads, checked word by word against a local support matrix model.
// Depends on cpsa_pkg and the cube_pair_support_accumulator RTL.
`timescale 1ns / 1ps

module tb_cube_pair_support_accumulator;
   import cpsa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 34;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_word_type  req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_word_type  rsp_data;

   // Model of the support matrix, one row per output
   row_type       support_model [FIELD_OUTS] = '{default: '0};
   // Result words owed by the block, oldest first
   rsp_word_type  pending_rsp [$];

   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int hold_left = 0;

   int cycle_count   = 0;
   int error_count   = 0;
   int checked_count = 0;
   int pair_count    = 0;
   int read_count    = 0;
   int found_count   = 0;

   cube_pair_support_accumulator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Predict the result of one accepted word and update the model matrix
   function automatic rsp_word_type accumulate_support(input req_word_type w);
      rsp_word_type             r;
      logic [2*FIELD_VARS-1:0]  diff;
      logic [FIELD_OUTS-1:0]    shared;
      int                       n_conf;
      int                       idx;
      r      = '0;
      n_conf = 0;
      idx    = 0;
      if (w.req_type == REQ_READ) begin
         read_count++;
         if (w.row_select < ACT_OUTS) r.support_row = support_model[w.row_select];
         return r;
      end
      pair_count++;
      shared = w.on_cube_outputs & w.off_cube_outputs;
      for (int o = ACT_OUTS; o < FIELD_OUTS; o++) shared[o] = 1'b0;
      diff = w.on_cube_inputs ^ w.off_cube_inputs;
      // a variable conflicts when both code bits differ
      for (int v = 0; v < ACT_VARS; v++) begin
         if (diff[2*v] && diff[2*v+1]) begin
            n_conf++;
            idx = v;
         end
      end
      r.shared_outputs = shared;
      if (shared != '0 && n_conf == 1) begin
         for (int o = 0; o < ACT_OUTS; o++)
            if (shared[o]) support_model[o][idx] = 1'b1;
         r.conflict_var = idx[VAR_IDX_W-1:0];
         r.var_found    = 1'b1;
         found_count++;
      end
      return r;
   endfunction

   // Compare one result word with the oldest expectation
   function automatic void check_result(input rsp_word_type got);
      rsp_word_type want;
      if (pending_rsp.size() == 0) begin
         $error("result word %h with no request outstanding", got);
         error_count++;
         return;
      end
      want = pending_rsp.pop_front();
      checked_count++;
      if (got.support_row !== want.support_row) begin
         $error("support_row: expected %h, actual %h", want.support_row, got.support_row);
         error_count++;
      end
      if (got.conflict_var !== want.conflict_var) begin
         $error("conflict_var: expected %0d, actual %0d", want.conflict_var, got.conflict_var);
         error_count++;
      end
      if (got.var_found !== want.var_found) begin
         $error("var_found: expected %b, actual %b", want.var_found, got.var_found);
         error_count++;
      end
      if (got.shared_outputs !== want.shared_outputs) begin
         $error("shared_outputs: expected %h, actual %h",
                want.shared_outputs, got.shared_outputs);
         error_count++;
      end
   endfunction

   function automatic req_word_type pair_word(input logic [2*FIELD_VARS-1:0] on_in,
                                              input logic [FIELD_OUTS-1:0]   on_out,
                                              input logic [2*FIELD_VARS-1:0] off_in,
                                              input logic [FIELD_OUTS-1:0]   off_out);
      req_word_type w;
      w                  = '0;
      w.req_type         = REQ_PAIR;
      w.on_cube_inputs   = on_in;
      w.on_cube_outputs  = on_out;
      w.off_cube_inputs  = off_in;
      w.off_cube_outputs = off_out;
      return w;
   endfunction

   function automatic req_word_type read_word(input logic [ROW_IDX_W-1:0] sel);
      req_word_type w;
      w            = '0;
      w.req_type   = REQ_READ;
      w.row_select = sel;
      return w;
   endfunction

   // Random word: mostly distance-one pairs with sparse outputs, plus reads and noise
   function automatic req_word_type random_word();
      req_word_type w;
      int           kind;
      int           hit;
      int           other;
      int           bitpos;
      logic [1:0]   flip;
      w.req_type         = REQ_PAIR;
      w.on_cube_inputs   = $urandom;
      w.off_cube_inputs  = $urandom;
      w.on_cube_outputs  = FIELD_OUTS'($urandom_range(16'hFFFF));
      w.off_cube_outputs = FIELD_OUTS'($urandom_range(16'hFFFF));
      w.row_select       = ROW_IDX_W'($urandom_range(15));
      kind = $urandom_range(99);
      if (kind < 20) begin
         w.req_type = REQ_READ;
      end else if (kind < 90) begin
         hit    = $urandom_range(ACT_VARS - 1);
         other  = $urandom_range(ACT_VARS - 1);
         bitpos = $urandom_range(FIELD_OUTS - 1);
         w.on_cube_outputs  = FIELD_OUTS'($urandom & $urandom & $urandom);
         w.off_cube_outputs = FIELD_OUTS'($urandom & $urandom & $urandom);
         if ($urandom_range(9) != 0) begin
            w.on_cube_outputs[bitpos]  = 1'b1;
            w.off_cube_outputs[bitpos] = 1'b1;
         end
         // 20..69 one conflict, 70..79 none, 80..89 two (or one if they coincide)
         for (int i = 0; i < FIELD_VARS; i++) begin
            flip = 2'($urandom_range(2));
            if (kind < 70 && i == hit) flip = 2'b11;
            else if (kind >= 80 && (i == hit || i == other)) flip = 2'b11;
            w.off_cube_inputs[2*i +: 2] = w.on_cube_inputs[2*i +: 2] ^ flip;
         end
      end
      return w;
   endfunction

   // Offer one word, with a random gap first, and wait for it to be taken
   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      if (send_idle && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(accumulate_support(w));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, plus a counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_ready <= !(recv_idle && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results outstanding",
                CYCLE_LIMIT, pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   // Extremes of every field, each conflict rule and reads around updates
   task automatic test_directed();
      req_word_type w;
      send_word(read_word(4'd0));
      send_word(read_word(4'd15));
      send_word(pair_word('0, '0, '0, '0));
      send_word(pair_word('1, '1, '1, '1));
      // every variable 00 against 11: sixteen conflicts
      send_word(pair_word('0, '1, '1, '1));
      // empty code on variable 0 only, output 0 shared
      send_word(pair_word(32'h0000_0000, 16'h0001, 32'h0000_0003, 16'h0001));
      // 01 against 10 on variable 15, all outputs shared
      send_word(pair_word(32'h4000_0000, 16'hFFFF, 32'h8000_0000, 16'hFFFF));
      // 01 against 11 is no conflict
      send_word(pair_word(32'h0000_0010, 16'h0004, 32'h0000_0030, 16'h0004));
      // one conflict on variable 5 but outputs disjoint
      send_word(pair_word(32'h0000_0000, 16'h00F0, 32'h0000_0C00, 16'h0F00));
      // two conflicts, variables 2 and 9
      send_word(pair_word(32'h0000_0000, 16'hFFFF, 32'h000C_0030, 16'hFFFF));
      // variable 7, shared outputs 3 and 14
      send_word(pair_word(32'hAAAA_AAAA, 16'h4108, 32'hAAAA_6AAA, 16'h4028));
      send_word(read_word(4'd0));
      send_word(read_word(4'd3));
      send_word(read_word(4'd7));
      send_word(read_word(4'd14));
      send_word(read_word(4'd15));
      // read with every other field set
      w            = '1;
      w.req_type   = REQ_READ;
      w.row_select = 4'd3;
      send_word(w);
      wait_all_results();
   endtask

   task automatic test_random_traffic(input int n);
      for (int i = 0; i < n; i++) begin
         // quiet stretch with no idling on either side
         send_idle = !(i >= 400 && i < 600);
         recv_idle = send_idle;
         send_word(random_word());
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
      wait_all_results();
   endtask

   // Long receiver hold-off while the sender keeps offering: input must stall
   task automatic test_backpressure();
      send_idle = 1'b0;
      hold_left = 200;
      for (int i = 0; i < 60; i++) send_word(random_word());
      send_idle = 1'b1;
      wait_all_results();
   endtask

   // Short bursts, each followed by a full drain
   task automatic test_drain_pause();
      for (int k = 0; k < 10; k++) begin
         for (int i = 0; i < 15; i++) send_word(random_word());
         wait_all_results();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(1000);
      test_backpressure();
      test_drain_pause();
      wait_all_results();
      repeat (6) @(posedge clock);
      $display("checked %0d result words: %0d cube pairs (%0d marked a support variable),",
               checked_count, pair_count, found_count);
      $display("%0d row reads, with random stalls, a long hold-off and drained bursts",
               read_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
